// ----- rtl/spd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream pattern deleter package
// Shared constants, request and result types and inter-module structs.
// ----------------------------------------------------------------------------
package spd_pkg;

  // Longest pattern the block can delete, and the partial-match store depth.
  localparam int MAX_PATTERN = 16;
  localparam int HELD_DEPTH  = MAX_PATTERN - 1;

  // Width of a byte count from 0 to MAX_PATTERN, and of the held length.
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int HL_W  = $clog2(MAX_PATTERN);

  // Configuration register widths.
  localparam int CFG_LEN_W   = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;

  // Saturating statistics counters.
  localparam int                 COUNT_W   = 24;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Request kinds.
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_LENGTH = 2'd0,
    CFG_PATTERN_LOW    = 2'd1,
    CFG_PATTERN_HIGH   = 2'd2
  } cfg_reg_e;

  // One input request.
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  // One result.
  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               last;
    logic [COUNT_W-1:0] seen_count;
    logic [COUNT_W-1:0] kept_count;
  } result_t;

  // Current pattern as seen by the matcher.
  typedef struct packed {
    logic [CFG_LEN_W-1:0]         pattern_length;
    logic [MAX_PATTERN-1:0][7:0]  pattern;
  } cfg_t;

  // A burst of results produced by one request.
  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] bytes;
    logic [LEN_W-1:0]            num_bytes;
    logic                        report;
    logic [COUNT_W-1:0]          seen_count;
    logic [COUNT_W-1:0]          kept_count;
  } burst_t;

endpackage

// ----- rtl/stream_pattern_deleter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream pattern deleter
// Deletes every leftmost, non-overlapping occurrence of a pattern from a
// byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on item (valid/ready). A text request carries one byte;
//   an end-of-text request flushes the held partial match and closes the
//   text with a report result carrying the seen and kept byte counts.
//   Results leave on result (valid/ready); the final result of each request
//   has last set. A text byte that emits nothing produces no result.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set the
//   pattern length and bytes and are taken at once; write only when idle.
// Timing:
//   A request passes an input register and then a result buffer before its
//   first result is offered. All pattern alignments are compared
//   combinationally, so one request is taken per cycle while each emits at
//   most one result and the receiver does not stall; a request that emits
//   more results holds back the next request while the result buffer
//   drains them one per cycle.
//   A stalled receiver backs up into the input, and nothing is dropped.
// Reset:
//   Clears the held match, both counters and the pattern (length 1, zero).
// ----------------------------------------------------------------------------
module stream_pattern_deleter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  spd_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output spd_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  spd_pkg::cfg_t   cfg;
  spd_pkg::burst_t load;
  logic            load_valid;
  logic            load_ready;

  // Pattern registers.
  spd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Matcher and partial-match state.
  spd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg        (cfg),
    .load_valid (load_valid),
    .load_ready (load_ready),
    .load       (load)
  );

  // Result buffer.
  spd_burst u_burst (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (load_valid),
    .load_ready   (load_ready),
    .load         (load),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- rtl/spd_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream pattern deleter configuration registers
// Holds the pattern length and pattern bytes written over the config port.
// ----------------------------------------------------------------------------
module spd_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [spd_pkg::CFG_DATA_W-1:0]      cfg_data,
  output spd_pkg::cfg_t                       cfg
);

  logic [spd_pkg::CFG_LEN_W-1:0]  pattern_length;
  logic [spd_pkg::CFG_DATA_W-1:0] pattern_low;
  logic [spd_pkg::CFG_DATA_W-1:0] pattern_high;

  // Writes are always taken; an index beyond the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= spd_pkg::CFG_LEN_W'(1);
      pattern_low    <= '0;
      pattern_high   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        spd_pkg::CFG_PATTERN_LENGTH: pattern_length <= cfg_data[spd_pkg::CFG_LEN_W-1:0];
        spd_pkg::CFG_PATTERN_LOW:    pattern_low    <= cfg_data;
        spd_pkg::CFG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack the pattern bytes; bytes past the sixteenth read as zero.
  always_comb begin
    cfg.pattern_length = pattern_length;
    for (int k = 0; k < spd_pkg::MAX_PATTERN; k++) begin
      if (k < 8) begin
        cfg.pattern[k] = pattern_low[8*k +: 8];
      end else if (k < 16) begin
        cfg.pattern[k] = pattern_high[8*(k-8) +: 8];
      end else begin
        cfg.pattern[k] = 8'h00;
      end
    end
  end

endmodule

// ----- rtl/spd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream pattern deleter core
// Input register, partial-match state and the parallel alignment matcher.
// Produces one burst of results per request.
// ----------------------------------------------------------------------------
module spd_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  spd_pkg::item_t  item,
  input  spd_pkg::cfg_t   cfg,
  output logic            load_valid,
  input  logic            load_ready,
  output spd_pkg::burst_t load
);

  localparam int MP = spd_pkg::MAX_PATTERN;
  localparam int HD = spd_pkg::HELD_DEPTH;
  localparam int LW = spd_pkg::LEN_W;
  localparam int HW = spd_pkg::HL_W;
  localparam int CW = spd_pkg::COUNT_W;

  // Input register.
  logic           s1_valid;
  spd_pkg::item_t s1_item;

  // Partial-match state.
  logic [7:0]    held [HD];
  logic [HW-1:0] held_len;
  logic [CW-1:0] seen;
  logic [CW-1:0] kept;

  // Matcher signals.
  logic [7:0]    win [MP];
  logic [7:0]    held_next [HD];
  logic [LW-1:0] n_len;
  logic [LW-1:0] len_cfg;
  logic [LW-1:0] cand_len;
  logic [MP-1:0] cand;
  logic          match_ok;
  logic          found;
  logic          full;
  logic [LW-1:0] start;
  logic [HW-1:0] held_len_next;
  logic          is_end;
  logic          fire;
  logic [LW-1:0] add_n;
  logic [CW:0]   kept_sum;
  logic [CW-1:0] kept_sat;
  logic [CW-1:0] seen_inc;

  assign is_end     = (s1_item.kind == spd_pkg::KIND_END);
  assign load_valid = s1_valid;
  assign fire       = s1_valid && load_ready;
  assign item_ready = !s1_valid || load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
  end

  // Window of held bytes followed by the new byte at position held_len.
  for (genvar j = 0; j < HD; j++) begin : g_win
    assign win[j] = (HW'(j) < held_len) ? held[j] : s1_item.data_byte;
  end
  assign win[HD] = s1_item.data_byte;

  // Compare every alignment of the window against the pattern prefix.
  always_comb begin
    n_len = LW'(held_len) + LW'(1);
    if (int'(cfg.pattern_length) > MP) begin
      len_cfg = LW'(MP);
    end else begin
      len_cfg = LW'(cfg.pattern_length);
    end
    cand_len = '0;
    match_ok = 1'b0;
    for (int p = 0; p < MP; p++) begin
      cand_len = n_len - LW'(p);
      match_ok = 1'b1;
      for (int k = 0; k < MP - p; k++) begin
        if ((LW'(k) < cand_len) && (win[p+k] != cfg.pattern[k])) begin
          match_ok = 1'b0;
        end
      end
      cand[p] = (LW'(p) < n_len) && (cand_len <= len_cfg) && match_ok;
    end
  end

  // Earliest matching start wins; a full-length match deletes the tail.
  always_comb begin
    found = 1'b0;
    start = n_len;
    for (int p = MP - 1; p >= 0; p--) begin
      if (cand[p]) begin
        found = 1'b1;
        start = LW'(p);
      end
    end
    full = found && ((n_len - start) == len_cfg);
    if (full || !found) begin
      held_len_next = '0;
    end else begin
      held_len_next = HW'(n_len - start);
    end
  end

  // Shift the surviving partial match down to the front of the store.
  always_comb begin
    for (int j = 0; j < HD; j++) begin
      held_next[j] = win[j];
    end
    for (int s = 0; s < MP; s++) begin
      for (int j = 0; (j < MP - s) && (j < HD); j++) begin
        if (start == LW'(s)) begin
          held_next[j] = win[s+j];
        end
      end
    end
  end

  // Saturating counters.
  always_comb begin
    add_n    = is_end ? LW'(held_len) : start;
    kept_sum = {1'b0, kept} + (CW+1)'(add_n);
    kept_sat = (kept_sum > (CW+1)'(spd_pkg::COUNT_MAX)) ? spd_pkg::COUNT_MAX
                                                        : kept_sum[CW-1:0];
    seen_inc = (seen == spd_pkg::COUNT_MAX) ? seen : seen + CW'(1);
  end

  // Burst handed to the output stage.
  always_comb begin
    for (int j = 0; j < MP; j++) begin
      load.bytes[j] = win[j];
    end
    load.num_bytes  = add_n;
    load.report     = is_end;
    load.seen_count = is_end ? seen : seen_inc;
    load.kept_count = kept_sat;
  end

  // State update once the burst has been handed over.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_len <= '0;
      seen     <= '0;
      kept     <= '0;
    end else if (fire) begin
      if (is_end) begin
        held_len <= '0;
        seen     <= '0;
        kept     <= '0;
      end else begin
        held_len <= held_len_next;
        seen     <= seen_inc;
        kept     <= kept_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !is_end) begin
      for (int j = 0; j < HD; j++) begin
        held[j] <= held_next[j];
      end
    end
  end

endmodule

// ----- rtl/spd_burst.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream pattern deleter result buffer
// Holds one burst; emits it in order, one result per cycle while result_ready.
// ----------------------------------------------------------------------------
module spd_burst (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  output logic             load_ready,
  input  spd_pkg::burst_t  load,
  output logic             result_valid,
  input  logic             result_ready,
  output spd_pkg::result_t result
);

  localparam int MP = spd_pkg::MAX_PATTERN;
  localparam int LW = spd_pkg::LEN_W;
  localparam int CW = spd_pkg::COUNT_W;

  logic [7:0]    bytes [MP];
  logic [LW-1:0] rem;
  logic          rpt;
  logic [CW-1:0] seen_count;
  logic [CW-1:0] kept_count;
  logic          is_last;
  logic          take;
  logic          do_load;

  assign result_valid = (rem != '0) || rpt;
  assign is_last      = ((rem == LW'(1)) && !rpt) || ((rem == '0) && rpt);
  assign take         = result_valid && result_ready;
  assign load_ready   = !result_valid || (result_ready && is_last);
  assign do_load      = load_valid && load_ready;

  // Burst occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      rpt <= 1'b0;
    end else if (do_load) begin
      rem <= load.num_bytes;
      rpt <= load.report;
    end else if (take) begin
      if (rem != '0) begin
        rem <= rem - LW'(1);
      end else begin
        rpt <= 1'b0;
      end
    end
  end

  // Byte queue shifts towards the head as results are taken.
  always_ff @(posedge clk) begin
    if (do_load) begin
      for (int j = 0; j < MP; j++) begin
        bytes[j] <= load.bytes[j];
      end
      seen_count <= load.seen_count;
      kept_count <= load.kept_count;
    end else if (take && (rem != '0)) begin
      for (int j = 0; j < MP - 1; j++) begin
        bytes[j] <= bytes[j+1];
      end
    end
  end

  // Present the head result; counts appear only on the last one.
  always_comb begin
    result.out_byte   = (rem != '0) ? bytes[0] : 8'h00;
    result.byte_valid = (rem != '0);
    result.last       = is_last;
    result.seen_count = is_last ? seen_count : '0;
    result.kept_count = is_last ? kept_count : '0;
  end

endmodule

// ----- dv/stream_pattern_deleter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream pattern deleter testbench
// Drives text and end-of-text requests with bursty timing, stalls the result
// side, and checks every result against a built-in model of the deletion.
// The configuration changes between phases, sometimes with a partial match
// still held.
// ----------------------------------------------------------------------------

// Tracks the pattern, the held partial match and the counters, and queues the
// results that each accepted request must produce.
class deleter_scoreboard;
  logic [spd_pkg::CFG_LEN_W-1:0]  pattern_length;
  logic [spd_pkg::CFG_DATA_W-1:0] pattern_low;
  logic [spd_pkg::CFG_DATA_W-1:0] pattern_high;
  logic [7:0]                     held [spd_pkg::MAX_PATTERN];
  int unsigned                    held_length;
  logic [spd_pkg::COUNT_W-1:0]    seen_total;
  logic [spd_pkg::COUNT_W-1:0]    kept_total;
  spd_pkg::result_t               expected_results [$];
  int unsigned requests   = 0;
  int unsigned checked    = 0;
  int unsigned kept_bytes = 0;
  int unsigned reports    = 0;
  int unsigned errors     = 0;

  function new();
    pattern_length = 1;
    pattern_low    = '0;
    pattern_high   = '0;
    held_length    = 0;
    seen_total     = '0;
    kept_total     = '0;
  endfunction

  function void write_register(spd_pkg::cfg_reg_e index,
                               logic [spd_pkg::CFG_DATA_W-1:0] value);
    case (index)
      spd_pkg::CFG_PATTERN_LENGTH: pattern_length = value[spd_pkg::CFG_LEN_W-1:0];
      spd_pkg::CFG_PATTERN_LOW:    pattern_low    = value;
      spd_pkg::CFG_PATTERN_HIGH:   pattern_high   = value;
      default: ;
    endcase
  endfunction

  function logic [7:0] pattern_byte(int k);
    if (k < 8) return pattern_low[8*k +: 8];
    return pattern_high[8*(k-8) +: 8];
  endfunction

  function int unsigned outstanding();
    return expected_results.size();
  endfunction

  // Queues one kept byte; the final one of a burst carries the counts.
  function void push_kept(logic [7:0] value, bit final_one);
    spd_pkg::result_t r;
    r = '0;
    if (kept_total != spd_pkg::COUNT_MAX) kept_total++;
    r.out_byte   = value;
    r.byte_valid = 1'b1;
    if (final_one) begin
      r.last       = 1'b1;
      r.seen_count = seen_total;
      r.kept_count = kept_total;
    end
    expected_results.push_back(r);
  endfunction

  function void note_request(spd_pkg::item_t it);
    logic [7:0]       window [spd_pkg::MAX_PATTERN];
    spd_pkg::result_t r;
    int               n;
    int               eff;
    int               start;
    int               span;
    bit               full;
    bit               ok;
    requests++;

    // End of text: flush the held bytes, then report and start a new text.
    if (it.kind == spd_pkg::KIND_END) begin
      for (int i = 0; i < held_length; i++) push_kept(held[i], 1'b0);
      r            = '0;
      r.last       = 1'b1;
      r.seen_count = seen_total;
      r.kept_count = kept_total;
      expected_results.push_back(r);
      held_length = 0;
      seen_total  = '0;
      kept_total  = '0;
      return;
    end

    for (int i = 0; i < held_length; i++) window[i] = held[i];
    window[held_length] = it.data_byte;
    n = held_length + 1;
    if (seen_total != spd_pkg::COUNT_MAX) seen_total++;

    eff = (pattern_length > spd_pkg::MAX_PATTERN) ? spd_pkg::MAX_PATTERN
                                                  : int'(pattern_length);
    start = n;
    full  = 1'b0;

    // The earliest start whose tail is a pattern prefix wins.
    if (eff != 0) begin
      for (int p = 0; p < n; p++) begin
        span = n - p;
        if (span <= eff) begin
          ok = 1'b1;
          for (int k = 0; k < span; k++)
            if (window[p+k] != pattern_byte(k)) ok = 1'b0;
          if (ok) begin
            start = p;
            full  = (span == eff);
            break;
          end
        end
      end
    end

    for (int i = 0; i < start; i++) push_kept(window[i], i == start - 1);

    if (full || start >= n) begin
      held_length = 0;
    end else begin
      held_length = n - start;
      for (int i = 0; i < held_length; i++) held[i] = window[start+i];
    end
  endfunction

  function void check_result(spd_pkg::result_t got);
    spd_pkg::result_t want;
    string            diffs;
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: ERROR unexpected result: byte %h valid %b last %b seen %0d kept %0d",
                 $time, got.out_byte, got.byte_valid, got.last, got.seen_count,
                 got.kept_count);
      return;
    end
    want = expected_results.pop_front();
    checked++;
    if (want.byte_valid) kept_bytes++;
    if (want.last && !want.byte_valid) reports++;

    diffs = "";
    if (got.out_byte   !== want.out_byte)   diffs = {diffs, " out_byte"};
    if (got.byte_valid !== want.byte_valid) diffs = {diffs, " byte_valid"};
    if (got.last       !== want.last)       diffs = {diffs, " last"};
    if (got.seen_count !== want.seen_count) diffs = {diffs, " seen_count"};
    if (got.kept_count !== want.kept_count) diffs = {diffs, " kept_count"};
    if (diffs != "") begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: ERROR result mismatch in%s", $time, diffs);
        $display("  got      byte %h valid %b last %b seen %0d kept %0d",
                 got.out_byte, got.byte_valid, got.last, got.seen_count, got.kept_count);
        $display("  expected byte %h valid %b last %b seen %0d kept %0d",
                 want.out_byte, want.byte_valid, want.last, want.seen_count,
                 want.kept_count);
      end
    end
  endfunction
endclass

module stream_pattern_deleter_tb;
  import spd_pkg::*;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  logic                   item_ready;
  item_t                  item         = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  deleter_scoreboard sb;
  int burst_left  = 0;
  int stall_left  = 0;
  int stall_mode  = 0;
  int mode_left   = 0;
  int settings    = 0;

  stream_pattern_deleter dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Result side: check each accepted result, then choose the next ready.
  // The stall style, from none to heavy, is redrawn when its period ends.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
      case (stall_mode)
        1: if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 4);
        2: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 12);
        default: ;
      endcase
    end
  end

  // Offers one request, inserting a random gap at the start of each burst.
  task automatic send_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_request(it);
    burst_left--;
  endtask

  task automatic send_text(input logic [7:0] value);
    item_t it;
    it.kind      = KIND_TEXT;
    it.data_byte = value;
    send_item(it);
  endtask

  task automatic send_end();
    item_t it;
    it.kind      = KIND_END;
    it.data_byte = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  // Waits until every expected result has arrived, then lets any silent
  // request still in the pipeline finish before the block counts as idle.
  task automatic settle();
    item_valid <= 1'b0;
    burst_left = 0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three pattern registers while the block is idle.
  task automatic configure(input logic [CFG_LEN_W-1:0] len,
                           input logic [CFG_DATA_W-1:0] low,
                           input logic [CFG_DATA_W-1:0] high);
    logic [CFG_DATA_W-1:0] value;
    cfg_reg_e              index;
    settle();
    for (int r = 0; r < 3; r++) begin
      index = cfg_reg_e'(r);
      case (index)
        CFG_PATTERN_LENGTH: value = CFG_DATA_W'(len);
        CFG_PATTERN_LOW:    value = low;
        default:            value = high;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= index;
      cfg_data  <= value;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_register(index, value);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // One random phase: a fresh pattern, then text built mostly from whole and
  // broken copies of it so that partial matches reach deep into the window.
  task automatic random_phase(input int phase, input int target);
    logic [7:0]           pat [MAX_PATTERN];
    logic [CFG_LEN_W-1:0] len;
    logic [CFG_DATA_W-1:0] low;
    logic [CFG_DATA_W-1:0] high;
    logic [7:0]           sym_a;
    logic [7:0]           sym_b;
    bit                   two_symbols;
    int                   eff;
    int                   sent;
    int                   pick;
    int                   cut;
    case (phase)
      0:       len = 5'd1;
      1:       len = 5'd16;
      2:       len = 5'($urandom_range(17, 31));
      3:       len = 5'd0;
      default: len = 5'($urandom_range(2, 15));
    endcase
    eff         = (len > MAX_PATTERN) ? MAX_PATTERN : int'(len);
    sym_a       = 8'($urandom_range(0, 255));
    sym_b       = 8'($urandom_range(0, 255));
    two_symbols = ($urandom_range(0, 3) != 0);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (two_symbols) pat[k] = $urandom_range(0, 1) ? sym_a : sym_b;
      else             pat[k] = 8'($urandom_range(0, 255));
      if (k < 8) low[8*k +: 8]      = pat[k];
      else       high[8*(k-8) +: 8] = pat[k];
    end
    configure(len, low, high);

    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 35 && eff > 0) begin
        for (int k = 0; k < eff; k++) send_text(pat[k]);
        sent += eff;
      end else if (pick < 55 && eff > 1) begin
        cut = $urandom_range(1, eff - 1);
        for (int k = 0; k < cut; k++) send_text(pat[k]);
        send_text($urandom_range(0, 1) ? sym_a : 8'($urandom_range(0, 255)));
        sent += cut + 1;
      end else if (pick < 85) begin
        send_text(pat[$urandom_range(0, (eff > 0) ? eff - 1 : MAX_PATTERN - 1)]);
        sent++;
      end else if (pick < 95) begin
        send_text(8'($urandom_range(0, 255)));
        sent++;
      end else begin
        send_end();
        sent++;
      end
    end
    // Leaving the text open half the time carries a held match into the
    // next pattern.
    if ($urandom_range(0, 1) == 1) send_end();
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset pattern is a single zero byte: the zero is deleted.
    send_text(8'h00);
    send_text(8'hFF);
    send_end();

    // Zero length: everything passes straight through.
    configure(5'd0, 64'd0, 64'd0);
    send_text(8'h00);
    send_text(8'hA5);
    send_end();

    // Longest pattern of all ones: a full held window then a mismatch emits
    // sixteen bytes from one request.
    configure(5'd16, '1, '1);
    repeat (15) send_text(8'hFF);
    send_text(8'h00);
    send_end();

    for (int phase = 0; phase < 8; phase++) random_phase(phase, 19);
    send_end();

    // Drain, then allow for anything still in the pipeline.
    item_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.outstanding() != 0) begin
      $display("ERROR: %0d expected results never arrived", sb.outstanding());
      sb.errors++;
    end
    $display("Run covered %0d requests under %0d pattern settings; %0d results checked.",
             sb.requests, settings, sb.checked);
    $display("Of those, %0d were kept bytes and %0d were end-of-text reports; %0d errors.",
             sb.kept_bytes, sb.reports, sb.errors);
    if (sb.errors == 0) begin
      $display("stream_pattern_deleter verification clean");
    end else begin
      $display("stream_pattern_deleter verification failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("ERROR: timeout with %0d results still expected", sb.outstanding());
    $display("stream_pattern_deleter verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/spd_pkg.sv
rtl/spd_cfg_regs.sv
rtl/spd_core.sv
rtl/spd_burst.sv
rtl/stream_pattern_deleter.sv
dv/stream_pattern_deleter_tb.sv
